// File: rtl/ipcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum verifier package
// Shared types, word positions and ones-complement helpers.
// ----------------------------------------------------------------------------
package ipcv_pkg;

   // Fixed word positions in the IPv4 header (16-bit word index).
   localparam logic [14:0] WORD_IHL        = 15'd0;
   localparam logic [14:0] WORD_TOTAL      = 15'd1;
   localparam logic [14:0] WORD_PROTO      = 15'd4;
   localparam logic [14:0] WORD_IP_CHECK   = 15'd5;
   localparam logic [14:0] WORD_ADDR_FIRST = 15'd6;
   localparam logic [14:0] WORD_ADDR_LAST  = 15'd9;
   // The TCP check word sits eight words into the segment.
   localparam logic [14:0] TCP_CHECK_OFS   = 15'd8;
   // The word index saturates here; later words are ignored.
   localparam logic [14:0] WORD_IDX_MAX    = 15'h7fff;

   // Packet state as it stands after the final word.
   typedef struct packed {
      logic [3:0]  header_words;
      logic [15:0] total_bytes;
      logic [7:0]  proto_value;
      logic [16:0] ip_accum;
      logic [16:0] tcp_accum;
      logic [15:0] ip_received;
      logic [15:0] tcp_received;
   } snap_type;

   // Result fields, ip_ok in the lowest bit.
   typedef struct packed {
      logic length_error;
      logic all_ok;
      logic tcp_ok;
      logic ip_ok;
   } verdict_type;

   // One end-around-carry addition of a word into a 17-bit sum.
   function automatic logic [16:0] add_eac(input logic [16:0] acc, input logic [15:0] w);
      return {1'b0, acc[15:0]} + {16'b0, acc[16]} + {1'b0, w};
   endfunction

   // Fold the carry back in and take the ones complement.
   function automatic logic [15:0] fold_invert(input logic [16:0] acc);
      logic [16:0] s;
      logic [15:0] s2;
      s  = {1'b0, acc[15:0]} + {16'b0, acc[16]};
      s2 = s[15:0] + {15'b0, s[16]};
      return ~s2;
   endfunction

endpackage

// File: rtl/ipv4_tcp_checksum_verifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum verifier
// Checks the IPv4 header checksum and the TCP checksum of one packet.
// ----------------------------------------------------------------------------
// Usage:
// A packet arrives on the req_ stream as 16-bit words in network byte order,
// the IP header first and TCP directly after it, one word per beat, with
// req_tlast on the final word. Words are taken at one beat per cycle while
// req_tready is high, with no gaps required between packets.
// For each packet exactly one beat leaves on the rsp_ stream, carrying the
// IP verdict, the TCP verdict (including the pseudo-header), their AND and
// a length error flag that is set when the total length is below the
// header length; a length error also clears the TCP verdict.
// The final word passes through the input register, then the finish
// register, then the result register. Throughput is one word per cycle
// while req_tready is high.
// Reset clears all control state and any half-received packet; the next
// accepted word is taken as the first word of a packet.
// When the receiver holds rsp_tready low, the result waits in the output
// register while words keep flowing; only once the finish register is also
// occupied does a further final word hold req_tready low.
// ----------------------------------------------------------------------------
module ipv4_tcp_checksum_verifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] data_word
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [0] ip_ok, [1] tcp_ok, [2] all_ok,
                                   // [3] length_error, [7:4] zero
);

   logic               snap_valid;
   logic               snap_ready;
   ipcv_pkg::snap_type snap;

   // Running sums and header fields, one word per cycle while req_tready is high.
   ipcv_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // Final comparison and the registered result beat.
   ipcv_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // A length error never comes with a passing TCP or combined verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[1] && !rsp_tdata[2])
      else $error("length error reported with a passing TCP verdict");

   // The combined verdict is the AND of the two checks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2] == (rsp_tdata[0] && rsp_tdata[1]))
      else $error("all_ok disagrees with ip_ok and tcp_ok");

   // A final packet state held back by the verdict stage must not change.
   assert property (@(posedge clock) disable iff (reset)
      snap_valid && !snap_ready |=> snap_valid && $stable(snap))
      else $error("stalled packet state changed");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");
`endif

endmodule

// File: rtl/ipcv_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum verifier: word accumulator
// Input register, header field capture and the two running checksums.
// ----------------------------------------------------------------------------
module ipcv_accum (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,
   input  logic               req_tlast,
   output logic               snap_valid,
   input  logic               snap_ready,
   output ipcv_pkg::snap_type snap
);

   logic        a_valid_ff, a_valid_in;
   logic [15:0] a_word_ff;
   logic        a_last_ff;
   logic        a_go;

   logic [14:0] index_ff, index_in;
   logic        idx_full_ff, idx_full_in;
   ipcv_pkg::snap_type state_ff, state_in, upd;

   logic [14:0] idx;
   logic [15:0] w;
   logic [4:0]  hdr16;
   logic [14:0] hdr16_x;
   logic [14:0] tcp_check_idx;
   logic [15:0] seg_word;
   logic [16:0] tcp_addr_sum;

   // A word leaves the input register unless it is a final word whose
   // snapshot cannot yet be handed on.
   assign a_go       = a_valid_ff && (!a_last_ff || snap_ready);
   assign req_tready = !a_valid_ff || a_go;
   assign a_valid_in = req_tready ? req_tvalid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_tvalid && req_tready) begin
         a_word_ff <= req_tdata;
         a_last_ff <= req_tlast;
      end
   end

   always_comb begin
      idx           = index_ff;
      w             = a_word_ff;
      upd           = state_ff;
      hdr16         = 5'd0;
      hdr16_x       = 15'd0;
      tcp_check_idx = 15'd0;
      seg_word      = w;
      tcp_addr_sum  = state_ff.tcp_accum;
      if (!idx_full_ff) begin
         if (idx == ipcv_pkg::WORD_IHL) begin
            upd.header_words = w[11:8];
         end
         if (idx == ipcv_pkg::WORD_TOTAL) begin
            upd.total_bytes = w;
         end
         if (idx == ipcv_pkg::WORD_PROTO) begin
            upd.proto_value = w[7:0];
         end
         if (idx == ipcv_pkg::WORD_IP_CHECK) begin
            upd.ip_received = w;
         end
         hdr16         = {upd.header_words, 1'b0};
         hdr16_x       = {10'b0, hdr16};
         tcp_check_idx = hdr16_x + ipcv_pkg::TCP_CHECK_OFS;
         if (idx == tcp_check_idx) begin
            upd.tcp_received = w;
         end
         // IP header sum, its own check word counted as zero.
         if (idx < hdr16_x) begin
            upd.ip_accum = ipcv_pkg::add_eac(state_ff.ip_accum,
               (idx == ipcv_pkg::WORD_IP_CHECK) ? 16'd0 : w);
         end
         // Addresses belong to the pseudo-header.
         if (idx >= ipcv_pkg::WORD_ADDR_FIRST && idx <= ipcv_pkg::WORD_ADDR_LAST) begin
            tcp_addr_sum = ipcv_pkg::add_eac(state_ff.tcp_accum, w);
         end
         upd.tcp_accum = tcp_addr_sum;
         // Segment words below the total length; odd tail byte padded.
         if (idx >= hdr16_x
               && (idx == ipcv_pkg::WORD_IHL || {idx, 1'b0} < upd.total_bytes)) begin
            if (idx == tcp_check_idx) begin
               seg_word = 16'd0;
            end else if ({idx, 1'b1} == upd.total_bytes) begin
               seg_word = {w[15:8], 8'd0};
            end
            upd.tcp_accum = ipcv_pkg::add_eac(tcp_addr_sum, seg_word);
         end
      end
   end

   assign snap       = upd;
   assign snap_valid = a_valid_ff && a_last_ff;

   always_comb begin
      index_in    = index_ff;
      idx_full_in = idx_full_ff;
      state_in    = state_ff;
      if (a_go) begin
         if (a_last_ff) begin
            index_in    = 15'd0;
            idx_full_in = 1'b0;
            state_in    = '0;
         end else begin
            state_in = upd;
            if (!idx_full_ff) begin
               if (index_ff == ipcv_pkg::WORD_IDX_MAX) begin
                  idx_full_in = 1'b1;
               end else begin
                  index_in = index_ff + 15'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= 15'd0;
         idx_full_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         index_ff    <= index_in;
         idx_full_ff <= idx_full_in;
         state_ff    <= state_in;
      end
   end

endmodule

// File: rtl/ipcv_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum verifier: verdict stage
// Holds the final packet state, completes the pseudo-header sum and
// registers the result beat.
// ----------------------------------------------------------------------------
module ipcv_verdict (
   input  logic               clock,
   input  logic               reset,
   input  logic               snap_valid,
   output logic               snap_ready,
   input  ipcv_pkg::snap_type snap,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata
);

   logic                  b_valid_ff, b_valid_in;
   ipcv_pkg::snap_type    b_snap_ff;
   logic                  c_ready;
   logic                  rsp_valid_ff, rsp_valid_in;
   ipcv_pkg::verdict_type rsp_data_ff, verdict;

   logic [15:0] hdr_bytes;
   logic [15:0] tcp_len;
   logic [16:0] tcp_sum;
   logic        len_err;

   assign c_ready    = !rsp_valid_ff || rsp_tready;
   assign snap_ready = !b_valid_ff || c_ready;
   assign b_valid_in = snap_ready ? snap_valid : b_valid_ff;
   assign rsp_valid_in = c_ready ? b_valid_ff : rsp_valid_ff;

   always_comb begin
      hdr_bytes = {10'b0, b_snap_ff.header_words, 2'b00};
      len_err   = b_snap_ff.total_bytes < hdr_bytes;
      tcp_len   = b_snap_ff.total_bytes - hdr_bytes;
      tcp_sum   = ipcv_pkg::add_eac(
                     ipcv_pkg::add_eac(b_snap_ff.tcp_accum, {8'b0, b_snap_ff.proto_value}),
                     tcp_len);
      verdict.ip_ok        = ipcv_pkg::fold_invert(b_snap_ff.ip_accum) == b_snap_ff.ip_received;
      verdict.tcp_ok       = !len_err
                             && ipcv_pkg::fold_invert(tcp_sum) == b_snap_ff.tcp_received;
      verdict.all_ok       = verdict.ip_ok && verdict.tcp_ok;
      verdict.length_error = len_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (snap_valid && snap_ready) begin
         b_snap_ff <= snap;
      end
      if (b_valid_ff && c_ready) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

endmodule

// File: bench/ipcv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum verifier checker
// Watches the word stream and the result stream. It predicts the verdict of
// every packet and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module ipcv_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] data_word
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,  // [0] ip_ok, [1] tcp_ok, [2] all_ok,
                                   // [3] length_error, [7:4] zero
   output int          fail_count,
   output int          pending
);

   // Running state of the packet being received.
   logic [14:0] word_idx;
   logic        idx_sat;
   logic [3:0]  ihl_q;
   logic [15:0] total_q;
   logic [7:0]  proto_q;
   logic [16:0] ip_sum;
   logic [16:0] tcp_sum;
   logic [15:0] ip_rx_q;
   logic [15:0] tcp_rx_q;

   ipcv_pkg::verdict_type expected_verdicts[$];
   int                    mismatches = 0;

   function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] w);
      logic [17:0] s;
      s = 18'(acc[15:0]) + 18'(acc[16]) + 18'(w);
      return s[16:0];
   endfunction

   function automatic logic [15:0] ones_fold_inv(input logic [16:0] acc);
      logic [16:0] s;
      logic [15:0] s2;
      s  = 17'(acc[15:0]) + 17'(acc[16]);
      s2 = s[15:0] + 16'(s[16]);
      return ~s2;
   endfunction

   task automatic clear_packet();
      word_idx = '0;
      idx_sat  = 1'b0;
      ihl_q    = '0;
      total_q  = '0;
      proto_q  = '0;
      ip_sum   = '0;
      tcp_sum  = '0;
      ip_rx_q  = '0;
      tcp_rx_q = '0;
   endtask

   // Folds one accepted word into the sums; on the final word the verdict is
   // worked out and queued, and the packet state starts afresh.
   task automatic take_word(input logic [15:0] w, input logic fin);
      int                    i;
      int                    hdr16;
      int                    hdr_bytes;
      logic [15:0]           v;
      logic [15:0]           seg_len;
      logic [16:0]           t;
      logic                  len_bad;
      ipcv_pkg::verdict_type vd;
      i = int'(word_idx);
      if (!idx_sat) begin
         if (word_idx == ipcv_pkg::WORD_IHL)      ihl_q   = w[11:8];
         if (word_idx == ipcv_pkg::WORD_TOTAL)    total_q = w;
         if (word_idx == ipcv_pkg::WORD_PROTO)    proto_q = w[7:0];
         if (word_idx == ipcv_pkg::WORD_IP_CHECK) ip_rx_q = w;
         hdr16 = 2 * int'(ihl_q);
         if (i == hdr16 + 8) tcp_rx_q = w;
         if (i < hdr16)
            ip_sum = ones_add(ip_sum, (word_idx == ipcv_pkg::WORD_IP_CHECK) ? 16'h0 : w);
         if (word_idx >= ipcv_pkg::WORD_ADDR_FIRST && word_idx <= ipcv_pkg::WORD_ADDR_LAST)
            tcp_sum = ones_add(tcp_sum, w);
         // Segment words count only inside the packet, word zero apart.
         if (i >= hdr16 && (i == 0 || 2 * i < int'(total_q))) begin
            v = w;
            if (i == hdr16 + 8) v = 16'h0;
            else if (2 * i + 1 == int'(total_q)) v = {w[15:8], 8'h00};
            tcp_sum = ones_add(tcp_sum, v);
         end
         if (word_idx == ipcv_pkg::WORD_IDX_MAX) idx_sat = 1'b1;
         else word_idx = word_idx + 15'd1;
      end
      if (fin) begin
         hdr_bytes       = 4 * int'(ihl_q);
         seg_len         = 16'(int'(total_q) - hdr_bytes);
         t               = ones_add(ones_add(tcp_sum, {8'h00, proto_q}), seg_len);
         len_bad         = int'(total_q) < hdr_bytes;
         vd.ip_ok        = ones_fold_inv(ip_sum) == ip_rx_q;
         vd.tcp_ok       = !len_bad && ones_fold_inv(t) == tcp_rx_q;
         vd.all_ok       = vd.ip_ok && vd.tcp_ok;
         vd.length_error = len_bad;
         expected_verdicts.push_back(vd);
         clear_packet();
      end
   endtask

   task automatic check_field(input string field, input logic want, input logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      ipcv_pkg::verdict_type got;
      ipcv_pkg::verdict_type want;
      if (reset) begin
         clear_packet();
         expected_verdicts.delete();
      end else begin
         // Results are checked before the word of this edge is taken, so a
         // verdict queued now can never be matched by an earlier beat.
         if (rsp_tvalid && rsp_tready) begin
            got = ipcv_pkg::verdict_type'(rsp_tdata[3:0]);
            if (expected_verdicts.size() == 0) begin
               $display("%0t: result beat with none expected, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("ip_ok", want.ip_ok, got.ip_ok);
               check_field("tcp_ok", want.tcp_ok, got.tcp_ok);
               check_field("all_ok", want.all_ok, got.all_ok);
               check_field("length_error", want.length_error, got.length_error);
            end
            if (rsp_tdata[7:4] !== 4'h0) begin
               $display("%0t: pad bits mismatch, expected 0, actual %h", $time, rsp_tdata[7:4]);
               mismatches++;
            end
         end
         if (req_tvalid && req_tready) take_word(req_tdata, req_tlast);
      end
      fail_count <= mismatches;
      pending    <= expected_verdicts.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum verifier testbench
// Drives packets into the verifier with bursty input and a stalling result
// side, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LIMIT_CYCLES = 1_000_000;
   // Random traffic carries on until this many words have gone in overall
   // and at least this many packets have been sent.
   localparam int RANDOM_UNTIL = 1000;
   localparam int MIN_PACKETS  = 30;
   // Long hold-off of the result side, used to fill the block up.
   localparam int LONG_HOLD    = 300;
   // Settling time after the last expected result.
   localparam int DRAIN_CYCLES = 40;
   localparam logic [7:0] PROTO_TCP = 8'd6;

   typedef enum logic [1:0] {RX_FREE, RX_BUSY, RX_SPARSE} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   int          fail_count;
   int          pending;

   // Handshake between the stimulus and the receiver for the long hold-off:
   // each flag has a single writer.
   logic        long_hold_req  = 1'b0;
   logic        long_hold_done = 1'b0;

   rx_mode_type rx_mode     = RX_FREE;
   int          rx_left     = 0;
   int          burst_left  = 0;
   int          beats_sent  = 0;
   int          packets_sent = 0;
   int          cycle_count = 0;

   // Words of the packet about to be sent, in wire order.
   logic [15:0] pkt_q[$];

   always #1 clock = ~clock;

   ipv4_tcp_checksum_verifier_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ipcv_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Internet checksum of a plain integer sum: fold all carries back in and
   // invert. Only used to build packets that ought to pass.
   function automatic logic [15:0] wire_checksum(input longint s);
      while ((s >> 16) != 0) s = (s & 64'hffff) + (s >> 16);
      return ~16'(s);
   endfunction

   // Builds a well-formed packet into pkt_q: an IPv4 header of ihl words of
   // 32 bits followed by seg_bytes of TCP segment, with each check word that
   // it holds filled in correctly. The protocol byte is not always TCP, so
   // the pseudo-header sum sees other values as well. ihl must be 5 or more.
   task automatic make_packet(input int ihl, input int seg_bytes);
      int     total;
      int     hw;
      int     sw;
      int     k;
      longint s;
      logic [15:0] w;
      pkt_q.delete();
      total = ihl * 4 + seg_bytes;
      hw    = 2 * ihl;
      sw    = (seg_bytes + 1) / 2;
      pkt_q.push_back({4'h4, 4'(ihl), 8'($urandom)});
      pkt_q.push_back(16'(total));
      pkt_q.push_back(16'($urandom));
      pkt_q.push_back(16'($urandom));
      pkt_q.push_back({8'($urandom), ($urandom_range(0, 7) == 0) ? 8'($urandom) : PROTO_TCP});
      pkt_q.push_back(16'h0);
      for (k = 6; k < hw + sw; k++) pkt_q.push_back(16'($urandom));
      s = 0;
      for (k = 0; k < hw; k++) if (k != 5) s += pkt_q[k];
      pkt_q[5] = wire_checksum(s);
      // The pseudo-header: both addresses, the protocol and the TCP length.
      s = longint'(pkt_q[6]) + pkt_q[7] + pkt_q[8] + pkt_q[9] + pkt_q[4][7:0] + seg_bytes;
      for (k = 0; k < sw; k++) begin
         if (k != 8) begin
            w = pkt_q[hw + k];
            // An odd final byte is summed with a zero low byte; the byte on
            // the wire keeps its random value so that padding is exercised.
            if (k == sw - 1 && (seg_bytes % 2) == 1) w[7:0] = 8'h00;
            s += w;
         end
      end
      if (sw > 8) pkt_q[hw + 8] = wire_checksum(s);
   endtask

   // Offers one word and returns once it has been accepted. The sender runs
   // in bursts; between bursts req_tvalid usually drops. A gap of zero
   // keeps req_tvalid high so that it is never lowered and raised in the
   // same step.
   task automatic send_beat(input logic [15:0] w, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 16'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_packet();
      int k;
      for (k = 0; k < pkt_q.size(); k++) send_beat(pkt_q[k], k == pkt_q.size() - 1);
      packets_sent++;
   endtask

   // Stops offering words and waits until every predicted verdict has come
   // back. The first wait lets the checker see the final beat.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int          ihl;
      int          seg;
      int          keep;
      int          idx;
      int          k;
      logic [15:0] w;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed packets. A single all-ones word gives a header length of
      // fifteen against a total of zero, so a length error. A single zero
      // word gives a header length of zero, where word zero also counts
      // towards the segment sum.
      send_beat(16'hffff, 1'b1);
      send_beat(16'h0000, 1'b1);
      // Header length zero with a short segment behind it.
      send_beat(16'h4000, 1'b0);
      send_beat(16'h0006, 1'b0);
      send_beat(16'h1234, 1'b1);
      // Short header of two 32-bit words: the protocol and check positions
      // are still read where a full header would have them.
      send_beat(16'h4200, 1'b0);
      send_beat(16'h0008, 1'b0);
      send_beat(16'hffff, 1'b0);
      send_beat(16'h0000, 1'b0);
      send_beat(16'h00ff, 1'b0);
      send_beat(16'habcd, 1'b1);
      // Total length below the header length; the packet also ends before
      // the check words arrive, so they stay zero.
      send_beat(16'h4f00, 1'b0);
      send_beat(16'h0003, 1'b0);
      send_beat(16'h8001, 1'b1);
      drain_results();

      // Random traffic: mostly well-formed packets, some of them damaged,
      // cut short, padded with trailing words, given a bad total or header
      // length, and now and then plain noise.
      while (beats_sent < RANDOM_UNTIL || packets_sent < MIN_PACKETS) begin
         if ($urandom_range(0, 15) == 0) begin
            pkt_q.delete();
            keep = $urandom_range(1, 24);
            for (k = 0; k < keep; k++) pkt_q.push_back(16'($urandom));
         end else begin
            ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
            seg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19) : $urandom_range(20, 40);
            make_packet(ihl, seg);
            case ($urandom_range(0, 11))
               0: begin
                  idx = $urandom_range(0, pkt_q.size() - 1);
                  pkt_q[idx] = pkt_q[idx] ^ (16'h1 << $urandom_range(0, 15));
               end
               1: begin
                  keep = $urandom_range(1, 4);
                  for (k = 0; k < keep; k++) pkt_q.push_back(16'($urandom));
               end
               2: begin
                  keep = $urandom_range(1, pkt_q.size() - 1);
                  while (pkt_q.size() > keep) void'(pkt_q.pop_back());
               end
               3: pkt_q[1] = 16'($urandom_range(0, ihl * 4 - 1));
               4: begin
                  w = pkt_q[0];
                  w[11:8] = 4'($urandom_range(0, 4));
                  pkt_q[0] = w;
               end
               default: ;
            endcase
         end
         send_packet();
      end
      drain_results();

      // Back-pressure: the receiver holds off for a long stretch while short
      // packets keep coming, so that results pile up inside the block and it
      // has to stall the word stream.
      long_hold_req <= 1'b1;
      for (k = 0; k < 16; k++) begin
         pkt_q.delete();
         keep = $urandom_range(1, 3);
         for (idx = 0; idx < keep; idx++) pkt_q.push_back(16'($urandom));
         send_packet();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result side: stretches of free flow, heavy stalling and light stalling
   // follow each other at random, with the one long hold-off on request.
   always begin : rx_stall
      @(posedge clock);
      if (long_hold_req && !long_hold_done) begin
         rsp_tready <= 1'b0;
         repeat (LONG_HOLD) @(posedge clock);
         long_hold_done <= 1'b1;
         rsp_tready     <= 1'b1;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_left = $urandom_range(5, 60);
         end
         rx_left--;
         case (rx_mode)
            RX_FREE:   rsp_tready <= 1'b1;
            RX_BUSY:   rsp_tready <= ($urandom_range(0, 3) == 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) != 0);
            default:   rsp_tready <= 1'b1;
         endcase
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

// File: ipv4_tcp_checksum_verifier_top.f
rtl/ipcv_pkg.sv
rtl/ipcv_accum.sv
rtl/ipcv_verdict.sv
rtl/ipv4_tcp_checksum_verifier_top.sv
bench/ipcv_checker.sv
bench/tb_top.sv
